[sv/hdlcd_pkg.sv]
// Shared constants and types for the HDLC async deframer.
// No dependencies; used by hdlc_async_deframer.
package hdlcd_pkg;

  // Frame length, in unescaped bytes, at which the deframer aborts it
  localparam int unsigned MAX_FRAME = 512;
  localparam int unsigned CNT_W     = $clog2(MAX_FRAME);

  // Framing bytes
  localparam logic [7:0] FLAG_BYTE = 8'h7E;
  localparam logic [7:0] ESC_BYTE  = 8'h7D;
  localparam logic [7:0] ESC_XOR   = 8'h20;

  // Trailing CRC bytes kept back in the delay line
  localparam int unsigned CRC_LEN = 2;

  typedef logic [CNT_W-1:0] cnt_t;
  typedef logic [7:0]       byte_t;

endpackage

[sv/hdlc_async_deframer.sv]
// HDLC async deframer: flag/escape decode, CRC strip and overflow abort.
// Uses hdlcd_pkg for framing constants and types.
//
// Usage:
//   Input channel (in_valid/in_ready/in_byte) carries one raw line byte per
//   beat. Output channel (out_valid/out_ready) carries one result beat:
//   a payload byte (out_byte_valid), an end-of-frame mark at the closing
//   flag (out_frame_end), or an abort mark (out_frame_abort) when a frame
//   reaches MAX_FRAME bytes; downstream drops the partial frame then.
//   Escape bytes and flags that close frames of two bytes or fewer give
//   no beat. Payload bytes leave two bytes late, so the CRC stays behind.
//   A result beat appears in the cycle after its input beat is accepted.
//   Throughput: one byte per cycle while out_ready holds, set by the single
//   output register; decode, shift and count logic are all combinational.
//   When the receiver stalls with a result waiting, in_ready drops until
//   that beat is taken; in_ready follows out_ready in the same cycle.
//   Reset (rst_n low, synchronous) clears the escape flag, the byte count
//   and the output valid; the two held bytes need no reset.
module hdlc_async_deframer (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       out_byte_valid,
  output logic       out_frame_end,
  output logic       out_frame_abort
);

  localparam int unsigned      CNT_W_L = hdlcd_pkg::CNT_W;
  localparam logic [CNT_W_L:0] MAX_CNT = (CNT_W_L + 1)'(hdlcd_pkg::MAX_FRAME);

  hdlcd_pkg::cnt_t  cnt_r, cnt_nxt;
  logic             esc_r, esc_nxt;
  hdlcd_pkg::byte_t hold0_r, hold0_nxt;
  hdlcd_pkg::byte_t hold1_r, hold1_nxt;

  logic             ovalid_r, ovalid_nxt;
  hdlcd_pkg::byte_t obyte_r, obyte_nxt;
  logic             obv_r, obv_nxt;
  logic             oend_r, oend_nxt;
  logic             oabort_r, oabort_nxt;

  logic             in_fire;
  logic             is_flag;
  logic             is_esc;
  hdlcd_pkg::byte_t data;
  logic [CNT_W_L:0] cnt_inc;
  logic             past_crc;

  // Accept while the output slot is empty or being drained
  assign in_ready = !ovalid_r || out_ready;
  assign in_fire  = in_valid && in_ready;

  assign is_flag  = (in_byte == hdlcd_pkg::FLAG_BYTE);
  assign is_esc   = (in_byte == hdlcd_pkg::ESC_BYTE);
  assign data     = esc_r ? (in_byte ^ hdlcd_pkg::ESC_XOR) : in_byte;
  assign cnt_inc  = {1'b0, cnt_r} + (CNT_W_L + 1)'(1);
  assign past_crc = ({1'b0, cnt_r} >= (CNT_W_L + 1)'(hdlcd_pkg::CRC_LEN));

  // Decode one beat: update state and build the result
  always_comb begin
    cnt_nxt    = cnt_r;
    esc_nxt    = esc_r;
    hold0_nxt  = hold0_r;
    hold1_nxt  = hold1_r;
    ovalid_nxt = ovalid_r && !out_ready;
    obyte_nxt  = obyte_r;
    obv_nxt    = obv_r;
    oend_nxt   = oend_r;
    oabort_nxt = oabort_r;
    if (in_fire) begin
      obyte_nxt  = '0;
      obv_nxt    = 1'b0;
      oend_nxt   = 1'b0;
      oabort_nxt = 1'b0;
      if (is_flag) begin
        // Close the frame; mark the end only if it held more than the CRC
        cnt_nxt    = '0;
        esc_nxt    = 1'b0;
        oend_nxt   = ({1'b0, cnt_r} > (CNT_W_L + 1)'(hdlcd_pkg::CRC_LEN));
        ovalid_nxt = oend_nxt;
      end else if (is_esc) begin
        esc_nxt = 1'b1;
      end else begin
        // Shift the delay line and count the byte
        esc_nxt   = 1'b0;
        hold0_nxt = hold1_r;
        hold1_nxt = data;
        if (cnt_inc >= MAX_CNT) begin
          cnt_nxt    = '0;
          oabort_nxt = 1'b1;
          ovalid_nxt = 1'b1;
        end else begin
          cnt_nxt    = cnt_inc[CNT_W_L-1:0];
          if (past_crc) begin
            obyte_nxt  = hold0_r;
            obv_nxt    = 1'b1;
            ovalid_nxt = 1'b1;
          end
        end
      end
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r    <= '0;
      esc_r    <= 1'b0;
      ovalid_r <= 1'b0;
    end else begin
      cnt_r    <= cnt_nxt;
      esc_r    <= esc_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  // Delay line and result payload
  always_ff @(posedge clk) begin
    hold0_r  <= hold0_nxt;
    hold1_r  <= hold1_nxt;
    obyte_r  <= obyte_nxt;
    obv_r    <= obv_nxt;
    oend_r   <= oend_nxt;
    oabort_r <= oabort_nxt;
  end

  assign out_valid       = ovalid_r;
  assign out_byte        = obyte_r;
  assign out_byte_valid  = obv_r;
  assign out_frame_end   = oend_r;
  assign out_frame_abort = oabort_r;

  // A result beat carries exactly one kind of mark
  a_one_kind: assert property (@(posedge clk) disable iff (!rst_n)
    ovalid_r |-> $onehot({obv_r, oend_r, oabort_r}))
    else $error("result beat with zero or several marks");

  // An accepted flag restarts the frame
  a_flag_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && is_flag) |=> (cnt_r == '0) && !esc_r)
    else $error("flag did not clear frame state");

  // An accepted escape arms the XOR for the next byte
  a_esc_arms: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && is_esc) |=> esc_r)
    else $error("escape not recorded");

  // Byte count never reaches the abort limit
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    ({1'b0, cnt_r} < MAX_CNT))
    else $error("byte count out of range");

  // Only a data byte can produce a payload or abort beat
  a_data_only: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && (is_flag || is_esc)) |=> !(ovalid_r && (obv_r || oabort_r)))
    else $error("payload from flag or escape");

endmodule

[tb/tb.sv]
// Self-checking testbench for hdlc_async_deframer: raw line bytes in, deframed beats out.
// Depends on hdlcd_pkg and hdlc_async_deframer; expected beats come from a local deframe model.
`timescale 1ns / 1ps

module tb;

  localparam int unsigned LINE_BYTES = 1750;

  // One expected output beat
  typedef struct packed {
    hdlcd_pkg::byte_t data;
    logic             data_ok;
    logic             fend;
    logic             fabort;
  } deframe_beat_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_ready;
  hdlcd_pkg::byte_t in_byte = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  hdlcd_pkg::byte_t out_byte;
  logic             out_byte_valid;
  logic             out_frame_end;
  logic             out_frame_abort;

  // Line bytes waiting for the driver, and beats the deframer still owes
  hdlcd_pkg::byte_t line_q[$];
  deframe_beat_t    owed_beats[$];

  // Model state: escape seen, unescaped bytes in frame, two-byte delay line
  logic             esc_seen = 1'b0;
  int unsigned      frame_len = 0;
  hdlcd_pkg::byte_t dly[0:1] = '{8'h00, 8'h00};

  int   err_cnt = 0;
  int   beats_seen = 0;
  logic in_took = 1'b0;

  // Sender burst control
  int burst_left = 0;
  int gap_left = 0;

  // Receiver stall pattern and one long hold-off
  int   rx_mode = 0;
  int   rx_seg_left = 0;
  int   hold_left = 0;
  logic hold_done = 1'b0;

  hdlc_async_deframer DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_byte        (in_byte),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_byte       (out_byte),
    .out_byte_valid (out_byte_valid),
    .out_frame_end  (out_frame_end),
    .out_frame_abort(out_frame_abort)
  );

  always #6 clk = ~clk;

  // Advance the deframe model by one line byte; return 1 when a beat is owed
  function automatic logic deframe_step(input hdlcd_pkg::byte_t raw,
                                        output deframe_beat_t beat);
    hdlcd_pkg::byte_t b;
    hdlcd_pkg::byte_t leaving;
    logic             emit;
    beat = '0;
    b = raw;
    if (raw == hdlcd_pkg::FLAG_BYTE) begin
      emit = (frame_len > hdlcd_pkg::CRC_LEN);
      frame_len = 0;
      esc_seen = 1'b0;
      beat.fend = emit;
      return emit;
    end
    if (raw == hdlcd_pkg::ESC_BYTE) begin
      esc_seen = 1'b1;
      return 1'b0;
    end
    if (esc_seen) begin
      b = b ^ hdlcd_pkg::ESC_XOR;
      esc_seen = 1'b0;
    end
    emit = (frame_len >= hdlcd_pkg::CRC_LEN);
    leaving = dly[0];
    dly[0] = dly[1];
    dly[1] = b;
    frame_len++;
    if (frame_len >= hdlcd_pkg::MAX_FRAME) begin
      frame_len = 0;
      beat.fabort = 1'b1;
      return 1'b1;
    end
    if (emit) begin
      beat.data = leaving;
      beat.data_ok = 1'b1;
    end
    return emit;
  endfunction

  // Queue a well-formed frame of n unescaped bytes, escaping some at random
  task automatic add_frame(input int n);
    hdlcd_pkg::byte_t v;
    for (int i = 0; i < n; i++) begin
      v = hdlcd_pkg::byte_t'($urandom_range(0, 255));
      if (v == hdlcd_pkg::FLAG_BYTE || v == hdlcd_pkg::ESC_BYTE ||
          ($urandom_range(0, 7) == 0 && (v ^ hdlcd_pkg::ESC_XOR) != hdlcd_pkg::FLAG_BYTE &&
           (v ^ hdlcd_pkg::ESC_XOR) != hdlcd_pkg::ESC_BYTE)) begin
        line_q.push_back(hdlcd_pkg::ESC_BYTE);
        line_q.push_back(v ^ hdlcd_pkg::ESC_XOR);
      end else begin
        line_q.push_back(v);
      end
    end
    line_q.push_back(hdlcd_pkg::FLAG_BYTE);
  endtask

  // Queue n raw bytes rich in flags and escapes
  task automatic add_noise(input int n);
    int pick;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(0, 7);
      if (pick == 0) line_q.push_back(hdlcd_pkg::FLAG_BYTE);
      else if (pick == 1) line_q.push_back(hdlcd_pkg::ESC_BYTE);
      else line_q.push_back(hdlcd_pkg::byte_t'($urandom_range(0, 255)));
    end
  endtask

  // Offer line bytes in bursts; hold each until accepted
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_took) begin
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        in_valid <= 1'b0;
      end else if (line_q.size() > 0) begin
        in_byte <= line_q.pop_front();
        in_valid <= 1'b1;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 40);
          gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Stall the receiver on a pattern of segments, plus one long hold-off
  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else if (!hold_done && beats_seen >= 300) begin
      hold_done <= 1'b1;
      hold_left <= 250;
      out_ready <= 1'b0;
    end else if (rx_seg_left == 0) begin
      rx_mode <= $urandom_range(0, 2);
      rx_seg_left <= $urandom_range(8, 64);
      out_ready <= 1'b1;
    end else begin
      rx_seg_left <= rx_seg_left - 1;
      if (rx_mode == 0) out_ready <= 1'b1;
      else if (rx_mode == 1) out_ready <= ($urandom_range(0, 99) >= 30);
      else out_ready <= ($urandom_range(0, 99) >= 75);
    end
  end

  // Check output beats against the oldest owed beat, then predict accepted input
  always @(posedge clk) begin
    deframe_beat_t want;
    deframe_beat_t got;
    if (!rst_n) begin
      in_took <= 1'b0;
    end else begin
      in_took <= in_valid && in_ready;
      if (out_valid && out_ready) begin
        beats_seen <= beats_seen + 1;
        if (owed_beats.size() == 0) begin
          $error("unexpected output beat: byte=%02h valid=%0b end=%0b abort=%0b",
                 out_byte, out_byte_valid, out_frame_end, out_frame_abort);
          err_cnt++;
        end else begin
          want = owed_beats.pop_front();
          got = '{out_byte, out_byte_valid, out_frame_end, out_frame_abort};
          if (got.data !== want.data) begin
            $error("out_byte: expected %02h, got %02h", want.data, got.data);
            err_cnt++;
          end
          if (got.data_ok !== want.data_ok) begin
            $error("out_byte_valid: expected %0b, got %0b", want.data_ok, got.data_ok);
            err_cnt++;
          end
          if (got.fend !== want.fend) begin
            $error("out_frame_end: expected %0b, got %0b", want.fend, got.fend);
            err_cnt++;
          end
          if (got.fabort !== want.fabort) begin
            $error("out_frame_abort: expected %0b, got %0b", want.fabort, got.fabort);
            err_cnt++;
          end
        end
      end
      if (in_valid && in_ready) begin
        if (deframe_step(in_byte, want)) owed_beats.push_back(want);
      end
    end
  end

  // Build the byte stream, release reset, drain, and report
  initial begin
    int k;
    int pick;
    // Directed: short frames, extreme values, escaped flag value,
    // escape after escape, and an escape cut off by a flag
    line_q = '{hdlcd_pkg::FLAG_BYTE,
               8'h01, hdlcd_pkg::FLAG_BYTE,
               8'h02, 8'h03, hdlcd_pkg::FLAG_BYTE,
               8'h00, 8'hFF, hdlcd_pkg::ESC_BYTE, 8'h5E, hdlcd_pkg::FLAG_BYTE,
               8'h11, 8'h22, hdlcd_pkg::ESC_BYTE, hdlcd_pkg::ESC_BYTE, 8'h5D, 8'h33,
               hdlcd_pkg::FLAG_BYTE,
               8'h44, 8'h55, 8'h66, hdlcd_pkg::ESC_BYTE, hdlcd_pkg::FLAG_BYTE};
    // Random frames; two oversized frames force aborts, one ending right at the limit
    k = 0;
    while (line_q.size() < LINE_BYTES || k <= 30) begin
      pick = $urandom_range(0, 9);
      if (k == 5) add_frame(hdlcd_pkg::MAX_FRAME);
      else if (k == 30) add_frame(hdlcd_pkg::MAX_FRAME + 3);
      else if (pick < 8) add_frame(($urandom_range(0, 3) == 0) ? $urandom_range(0, 3)
                                                               : $urandom_range(4, 24));
      else if (pick == 8) add_noise($urandom_range(1, 30));
      else begin
        // broken frame: escape dropped by the closing flag
        add_frame($urandom_range(0, 10));
        void'(line_q.pop_back());
        line_q.push_back(hdlcd_pkg::ESC_BYTE);
        line_q.push_back(hdlcd_pkg::FLAG_BYTE);
      end
      k++;
    end

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (line_q.size() > 0 || in_valid || owed_beats.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);

    if (err_cnt == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Bound the run well beyond the slowest legal drain
  initial begin
    #2000000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
